/* rtl/core/rgb_pixel_blend_modes_assert.svh */
// Assertion macros shared by the blend pipeline RTL.
// Each macro clocks on the given clock and is disabled while reset is low.
`ifndef RGB_PIXEL_BLEND_MODES_ASSERT_SVH
`define RGB_PIXEL_BLEND_MODES_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPBM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("blend pipeline check failed");

// Consequent must hold in the cycle after the antecedent.
`define RPBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("blend pipeline check failed");

`endif

/* rtl/core/rpbm_pkg.sv */
// Package for the RGB blend pipeline: mode codes, register addresses,
// and the configuration struct handed to each channel. No dependencies.
package rpbm_pkg;

    // blend mode codes
    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_MULTIPLY   = 3'd1;
    localparam logic [2:0] MODE_SCREEN     = 3'd2;
    localparam logic [2:0] MODE_OVERLAY    = 3'd3;
    localparam logic [2:0] MODE_DIFFERENCE = 3'd4;

    // register index as seen on paddr[2]
    localparam logic REG_BLEND_MODE   = 1'b0;
    localparam logic REG_BLEND_WEIGHT = 1'b1;

    localparam logic [2:0] MODE_RESET   = MODE_NORMAL;
    localparam logic [8:0] WEIGHT_RESET = 9'd128;
    localparam logic [8:0] WEIGHT_ONE   = 9'd256;

    // configuration seen by the channel pipes
    typedef struct packed {
        logic [2:0] mode;
        logic [8:0] weight;
    } cfg_t;

endpackage

/* rtl/core/rpbm_chan.sv */
// One color channel of the blend pipeline: four register stages
// (operand select, multiply, bias add, quotient estimate) plus final fixup.
// Depends on rpbm_pkg.
module rpbm_chan (
    input  logic              aclk,
    input  logic              en,
    input  rpbm_pkg::cfg_t    cfg,
    input  logic [7:0]        a_chan,
    input  logic [7:0]        b_chan,
    output logic [7:0]        result
);

    // stage 1: operands
    logic [2:0]        s1_mode_reg;
    logic signed [8:0] s1_x_reg;
    logic [8:0]        s1_y_reg;
    logic [15:0]       s1_bias_reg;
    logic [7:0]        s1_diff_reg;
    logic              s1_hi_reg;
    // stage 2: product
    logic [2:0]         s2_mode_reg;
    logic signed [18:0] s2_prod_reg;
    logic [15:0]        s2_bias_reg;
    logic [7:0]         s2_diff_reg;
    logic               s2_hi_reg;
    // stage 3: numerator
    logic [2:0]  s3_mode_reg;
    logic [16:0] s3_num_reg;
    logic [7:0]  s3_diff_reg;
    logic        s3_hi_reg;
    // stage 4: quotient estimate
    logic [2:0]  s4_mode_reg;
    logic [16:0] s4_num_reg;
    logic [8:0]  s4_quo_reg;
    logic [7:0]  s4_diff_reg;
    logic        s4_hi_reg;

    logic signed [8:0]  x_next;
    logic [8:0]         y_next;
    logic [15:0]        bias_next;
    logic [7:0]         diff_next;
    logic               hi_next;
    logic [8:0]         f_sat;
    logic [7:0]         inv_a;
    logic [7:0]         inv_b;
    logic signed [18:0] prod_next;
    logic signed [19:0] num_sum;
    logic [17:0]        est_sum;
    logic signed [18:0] rem;
    logic [8:0]         quo_fix;

    // operand select per mode
    always_comb begin
        f_sat     = (cfg.weight > rpbm_pkg::WEIGHT_ONE) ? rpbm_pkg::WEIGHT_ONE : cfg.weight;
        inv_a     = ~a_chan;
        inv_b     = ~b_chan;
        diff_next = (a_chan > b_chan) ? (a_chan - b_chan) : (b_chan - a_chan);
        hi_next   = a_chan[7];
        x_next    = '0;
        y_next    = '0;
        bias_next = '0;
        unique case (cfg.mode)
            rpbm_pkg::MODE_NORMAL: begin
                // a*(256-f) + b*f + 128 = a*256 + (b-a)*f + 128
                x_next    = $signed({1'b0, b_chan}) - $signed({1'b0, a_chan});
                y_next    = f_sat;
                bias_next = {a_chan, 8'h80};
            end
            rpbm_pkg::MODE_MULTIPLY: begin
                x_next    = $signed({1'b0, a_chan});
                y_next    = {1'b0, b_chan};
                bias_next = 16'd127;
            end
            rpbm_pkg::MODE_SCREEN: begin
                x_next    = $signed({1'b0, inv_a});
                y_next    = {1'b0, inv_b};
                bias_next = 16'd127;
            end
            rpbm_pkg::MODE_OVERLAY: begin
                if (!a_chan[7]) begin
                    x_next    = $signed({a_chan, 1'b0});
                    y_next    = {1'b0, b_chan};
                    bias_next = 16'd0;
                end else begin
                    x_next    = $signed({inv_a, 1'b0});
                    y_next    = {1'b0, inv_b};
                    bias_next = 16'd254;
                end
            end
            default: begin
                x_next    = '0;
                y_next    = '0;
                bias_next = '0;
            end
        endcase
    end

    // multiply, bias add, quotient estimate for divide by 255
    assign prod_next = s1_x_reg * $signed({1'b0, s1_y_reg});
    assign num_sum   = $signed({s2_prod_reg[18], s2_prod_reg})
                     + $signed({4'b0, s2_bias_reg});
    assign est_sum   = {1'b0, s3_num_reg} + {9'b0, s3_num_reg[16:8]} + 18'd1;

    // pipeline registers, advance together
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_mode_reg <= cfg.mode;
            s1_x_reg    <= x_next;
            s1_y_reg    <= y_next;
            s1_bias_reg <= bias_next;
            s1_diff_reg <= diff_next;
            s1_hi_reg   <= hi_next;

            s2_mode_reg <= s1_mode_reg;
            s2_prod_reg <= prod_next;
            s2_bias_reg <= s1_bias_reg;
            s2_diff_reg <= s1_diff_reg;
            s2_hi_reg   <= s1_hi_reg;

            s3_mode_reg <= s2_mode_reg;
            s3_num_reg  <= num_sum[16:0];
            s3_diff_reg <= s2_diff_reg;
            s3_hi_reg   <= s2_hi_reg;

            s4_mode_reg <= s3_mode_reg;
            s4_num_reg  <= s3_num_reg;
            s4_quo_reg  <= est_sum[16:8];
            s4_diff_reg <= s3_diff_reg;
            s4_hi_reg   <= s3_hi_reg;
        end
    end

    // estimate is within one of the true quotient; fix with the remainder
    assign rem = $signed({2'b0, s4_num_reg})
               - $signed({2'b0, s4_quo_reg, 8'b0})
               + $signed({10'b0, s4_quo_reg});

    always_comb begin
        if (rem < 0) begin
            quo_fix = s4_quo_reg - 9'd1;
        end else if (rem >= 19'sd255) begin
            quo_fix = s4_quo_reg + 9'd1;
        end else begin
            quo_fix = s4_quo_reg;
        end
    end

    // final result per mode
    always_comb begin
        unique case (s4_mode_reg)
            rpbm_pkg::MODE_NORMAL:     result = s4_num_reg[15:8];
            rpbm_pkg::MODE_MULTIPLY:   result = quo_fix[7:0];
            rpbm_pkg::MODE_SCREEN:     result = 8'hFF - quo_fix[7:0];
            rpbm_pkg::MODE_OVERLAY:    result = s4_hi_reg ? (8'hFF - quo_fix[7:0])
                                                          : quo_fix[7:0];
            rpbm_pkg::MODE_DIFFERENCE: result = s4_diff_reg;
            default:                   result = 8'h00;
        endcase
    end

endmodule

/* rtl/core/rgb_pixel_blend_modes.sv */
// Top level of the RGB blend pipeline: config registers, three channel pipes,
// valid tracking, output register with skid stage. Depends on rpbm_pkg,
// rpbm_chan and rgb_pixel_blend_modes_assert.svh.
//
// Blends a pixel of image A with one of image B, channel by channel, under the
// mode in blend_mode (normal, multiply, screen, overlay, difference; other codes
// give black). One pixel transaction is taken every cycle while s_tready is high;
// each passes through four stages in each channel pipe (operand select, 9x10
// multiply, bias add, divide-by-255 estimate) and then the output register on the
// master side. A one-entry skid stage behind the output register keeps s_tready a
// registered signal, so a stall on m_tready reaches the input through
// skid_full_reg without loss. Write blend_mode and blend_weight only while no
// pixel is in flight.
`include "rgb_pixel_blend_modes_assert.svh"

module rgb_pixel_blend_modes (
    input  logic        aclk,
    input  logic        aresetn,
    // APB config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input pixel pair
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // a_red, a_green, a_blue, b_red, b_green, b_blue
    // blended pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // out_red, out_green, out_blue
);

    localparam int unsigned NumStages = 4;

    logic [2:0]            mode_reg;
    logic [8:0]            weight_reg;
    logic [NumStages-1:0]  vld_reg;
    logic [NumStages-1:0]  vld_next;
    logic                  skid_full_reg;
    logic [23:0]           skid_data_reg;
    logic [23:0]           out_data_reg;
    logic                  out_valid_reg;
    logic                  pipe_en;
    logic                  push;
    logic                  cfg_write;
    rpbm_pkg::cfg_t        cfg;
    logic [23:0]           pipe_data;

    // config registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= rpbm_pkg::MODE_RESET;
            weight_reg <= rpbm_pkg::WEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                rpbm_pkg::REG_BLEND_MODE:   mode_reg   <= pwdata[2:0];
                rpbm_pkg::REG_BLEND_WEIGHT: weight_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rpbm_pkg::REG_BLEND_MODE:   prdata = {29'b0, mode_reg};
            rpbm_pkg::REG_BLEND_WEIGHT: prdata = {23'b0, weight_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.mode   = mode_reg;
    assign cfg.weight = weight_reg;

    // pipe advances while the skid stage is empty
    assign pipe_en  = !skid_full_reg;
    assign s_tready = pipe_en;
    assign push     = pipe_en && vld_reg[NumStages-1];
    assign vld_next = {vld_reg[NumStages-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= vld_next;
        end
    end

    // channel pipes
    rpbm_chan u_red (
        .aclk   (aclk),
        .en     (pipe_en),
        .cfg    (cfg),
        .a_chan (s_tdata[7:0]),
        .b_chan (s_tdata[31:24]),
        .result (pipe_data[7:0])
    );

    rpbm_chan u_green (
        .aclk   (aclk),
        .en     (pipe_en),
        .cfg    (cfg),
        .a_chan (s_tdata[15:8]),
        .b_chan (s_tdata[39:32]),
        .result (pipe_data[15:8])
    );

    rpbm_chan u_blue (
        .aclk   (aclk),
        .en     (pipe_en),
        .cfg    (cfg),
        .a_chan (s_tdata[23:16]),
        .b_chan (s_tdata[47:40]),
        .result (pipe_data[23:16])
    );

    // output register with one-entry skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (out_valid_reg && !m_tready) begin
            if (push) begin
                skid_full_reg <= 1'b1;
            end
        end else if (skid_full_reg) begin
            out_valid_reg <= 1'b1;
            skid_full_reg <= 1'b0;
        end else begin
            out_valid_reg <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_tready) begin
            if (push) begin
                skid_data_reg <= pipe_data;
            end
        end else if (skid_full_reg) begin
            out_data_reg <= skid_data_reg;
        end else if (push) begin
            out_data_reg <= pipe_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    `RPBM_ASSERT_SAME(a_skid_needs_out, aclk, aresetn, skid_full_reg, out_valid_reg)
    `RPBM_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_full_reg && m_tready, !skid_full_reg)
    `RPBM_ASSERT_NEXT(a_stall_holds_pipe, aclk, aresetn, !pipe_en, vld_reg == $past(vld_reg))

endmodule
